// ===== rtl/core/bbc_pkg.sv =====
// Shared types and constants for the LRU block buffer cache core.
`default_nettype none

package bbc_pkg;

  // Field widths of the stream words
  localparam int DEV_W  = 8;
  localparam int BLK_W  = 32;
  localparam int REFS_W = 8;
  localparam int SLOT_W = 4;

  localparam int DEFAULT_SLOTS = 16;

  localparam logic [REFS_W-1:0] REFS_MAX = 8'd255;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_MARK    = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFREE   = 2'd1,
    ST_UNREF    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_t;

  // Tag and bookkeeping of one buffer slot
  typedef struct packed {
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
    logic [REFS_W-1:0] refs;
    logic              valid;
  } entry_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic             clr;    // drop all marks
    logic             step;   // rotate the chain by one position
    logic             move;   // shift marked prefix back, insert carry at head
    logic             retag;  // retag the victim-marked cell
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/block_buffer_cache_lru_core.sv =====
// Top level: chain of slot cells in recency order plus the sequencer.
// Each word is taken in the idle state, then one rotation pass of the cell chain runs
// with the head inspected each cycle, then the apply state loads the registered result.
// A new word is accepted only after apply; apply waits while a held result is not taken.
// Reset (synchronous): tags, counts and valid bits clear; recency order is
// descending slot numbers, most recent first. No clearing pass is needed.
`default_nettype none

module block_buffer_cache_lru_core
  import bbc_pkg::*;
#(
  parameter int SLOTS = DEFAULT_SLOTS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // device_id[7:0], block_number[39:8], slot[43:40], pad
  input  wire logic [1:0]  s_tuser,  // opcode[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata   // slot_out[3:0], hit[4], need_fill[5], status[7:6]
);

  localparam int ID_W = $clog2(SLOTS);

  entry_t            ent_q [SLOTS];
  logic [ID_W-1:0]   id_q  [SLOTS];
  logic [SLOTS-1:0]  vmark_q;
  logic [SLOTS-1:0]  bmark_q;

  entry_t            tail_ent, carry_ent;
  logic [ID_W-1:0]   tail_id, carry_id;
  logic              tail_vmark, tail_bmark, clr_vmark;
  cell_ctl_t         ctl;

  bbc_ctrl #(
    .SLOTS (SLOTS),
    .ID_W  (ID_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .head_ent   (ent_q[0]),
    .head_id    (id_q[0]),
    .tail_ent   (tail_ent),
    .tail_id    (tail_id),
    .tail_vmark (tail_vmark),
    .tail_bmark (tail_bmark),
    .clr_vmark  (clr_vmark),
    .carry_ent  (carry_ent),
    .carry_id   (carry_id),
    .ctl        (ctl)
  );

  // Cell chain: position 0 is the most recent end
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    entry_t          rot_ent, prev_ent;
    logic [ID_W-1:0] rot_id, prev_id;
    logic            rot_vmark, rot_bmark, prev_bmark;

    if (k == SLOTS - 1) begin : g_tail
      assign rot_ent   = tail_ent;
      assign rot_id    = tail_id;
      assign rot_vmark = tail_vmark;
      assign rot_bmark = tail_bmark;
    end else begin : g_mid
      assign rot_ent   = ent_q[k+1];
      assign rot_id    = id_q[k+1];
      assign rot_vmark = vmark_q[k+1] & ~clr_vmark;
      assign rot_bmark = bmark_q[k+1];
    end

    if (k == 0) begin : g_head
      assign prev_ent   = carry_ent;
      assign prev_id    = carry_id;
      assign prev_bmark = 1'b1;
    end else begin : g_body
      assign prev_ent   = ent_q[k-1];
      assign prev_id    = id_q[k-1];
      assign prev_bmark = bmark_q[k-1];
    end

    bbc_cell #(
      .ID_W   (ID_W),
      .RST_ID (ID_W'(SLOTS - 1 - k))
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .rot_ent    (rot_ent),
      .rot_id     (rot_id),
      .rot_vmark  (rot_vmark),
      .rot_bmark  (rot_bmark),
      .prev_ent   (prev_ent),
      .prev_id    (prev_id),
      .prev_bmark (prev_bmark),
      .ent        (ent_q[k]),
      .id         (id_q[k]),
      .vmark      (vmark_q[k]),
      .bmark      (bmark_q[k])
    );
  end

  // At most one victim candidate is marked at any time
  a_one_victim: assert property (@(posedge clk) disable iff (rst)
    $onehot0(vmark_q))
    else $error("more than one victim mark in the chain");

  // Chain operations never overlap
  a_ctl_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.clr, ctl.step, ctl.move, ctl.retag}))
    else $error("overlapping chain operations");

  // One word in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted during a pass");

  // A hit result always carries an ok status
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[4]) |-> (m_tdata[7:6] == ST_OK))
    else $error("hit reported with error status");

endmodule

`default_nettype wire

// ===== rtl/core/bbc_cell.sv =====
// One recency position of the chain: holds a slot's tag, count, valid and marks.
`default_nettype none

module bbc_cell
  import bbc_pkg::*;
#(
  parameter int              ID_W   = 4,
  parameter logic [ID_W-1:0] RST_ID = '0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cell_ctl_t       ctl,
  // from the next cell toward the tail (rotation)
  input  wire entry_t          rot_ent,
  input  wire logic [ID_W-1:0] rot_id,
  input  wire logic            rot_vmark,
  input  wire logic            rot_bmark,
  // from the previous cell toward the head (move to front)
  input  wire entry_t          prev_ent,
  input  wire logic [ID_W-1:0] prev_id,
  input  wire logic            prev_bmark,
  output entry_t               ent,
  output logic [ID_W-1:0]      id,
  output logic                 vmark,
  output logic                 bmark
);

  // Clear marks, hold, rotate, shift toward the tail, or retag in place
  always_ff @(posedge clk) begin
    if (rst) begin
      ent   <= '0;
      id    <= RST_ID;
      vmark <= 1'b0;
      bmark <= 1'b0;
    end else begin
      priority if (ctl.clr) begin
        vmark <= 1'b0;
        bmark <= 1'b0;
      end else if (ctl.step) begin
        ent   <= rot_ent;
        id    <= rot_id;
        vmark <= rot_vmark;
        bmark <= rot_bmark;
      end else if (ctl.move && prev_bmark) begin
        ent <= prev_ent;
        id  <= prev_id;
      end else if (ctl.retag && vmark) begin
        ent.dev   <= ctl.dev;
        ent.blk   <= ctl.blk;
        ent.refs  <= REFS_W'(1);
        ent.valid <= 1'b0;
      end else begin
        // hold
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bbc_ctrl.sv =====
// Sequencer: takes words, inspects the chain head during the rotation pass, builds results.
`default_nettype none

module bbc_ctrl
  import bbc_pkg::*;
#(
  parameter int SLOTS = DEFAULT_SLOTS,
  parameter int ID_W  = $clog2(SLOTS)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  // input stream
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [47:0]     s_tdata,   // device_id, block_number, slot, zero pad
  input  wire logic [1:0]      s_tuser,   // opcode
  // output stream
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [7:0]           m_tdata,   // slot_out, hit, need_fill, status
  // chain head and tail
  input  wire entry_t          head_ent,
  input  wire logic [ID_W-1:0] head_id,
  output entry_t               tail_ent,
  output logic [ID_W-1:0]      tail_id,
  output logic                 tail_vmark,
  output logic                 tail_bmark,
  output logic                 clr_vmark,
  output entry_t               carry_ent,
  output logic [ID_W-1:0]      carry_id,
  output cell_ctl_t            ctl
);

  localparam int SW = (ID_W > SLOT_W) ? ID_W : SLOT_W;

  state_t state, state_next;

  op_t               op;
  logic [DEV_W-1:0]  dev;
  logic [BLK_W-1:0]  blk;
  logic [SLOT_W-1:0] slot;
  logic [ID_W-1:0]   cnt;
  logic              found, found_next;
  logic              got, got_next;
  logic              move, move_next;
  status_t           status, status_next;
  logic [SLOT_W-1:0] slot_out, slot_out_next;
  logic              hit, hit_next;
  logic              fill, fill_next;
  logic [SLOT_W-1:0] victim, victim_next;
  entry_t            carry_ent_next;
  logic [ID_W-1:0]   carry_id_next;

  logic              accept, fire;
  logic [SW-1:0]     head_id_x, slot_x;
  logic              tag_eq, slot_eq;

  assign head_id_x = SW'(head_id);
  assign slot_x    = SW'(slot);
  assign tag_eq    = (head_ent.dev == dev) && (head_ent.blk == blk);
  assign slot_eq   = (head_id_x == slot_x);

  // Inspect the head entry and form what goes back in at the tail
  always_comb begin
    tail_ent       = head_ent;
    tail_id        = head_id;
    tail_vmark     = 1'b0;
    tail_bmark     = 1'b0;
    clr_vmark      = 1'b0;
    found_next     = found;
    got_next       = got;
    move_next      = move;
    status_next    = status;
    slot_out_next  = slot_out;
    hit_next       = hit;
    fill_next      = fill;
    victim_next    = victim;
    carry_ent_next = carry_ent;
    carry_id_next  = carry_id;
    unique case (op)
      OP_ACQUIRE: begin
        if (!found && tag_eq) begin
          found_next = 1'b1;
          if (head_ent.refs == REFS_MAX) begin
            status_next = ST_OVERFLOW;
          end else begin
            tail_ent.refs = head_ent.refs + REFS_W'(1);
            slot_out_next = head_id_x[SLOT_W-1:0];
            hit_next      = 1'b1;
            fill_next     = ~head_ent.valid;
          end
        end
        // Latest free entry seen is the least recent one so far
        if (head_ent.refs == '0) begin
          tail_vmark  = 1'b1;
          clr_vmark   = 1'b1;
          got_next    = 1'b1;
          victim_next = head_id_x[SLOT_W-1:0];
        end
      end
      OP_RELEASE: begin
        if (!found && slot_eq) begin
          found_next = 1'b1;
          if (head_ent.refs == '0) begin
            status_next = ST_UNREF;
          end else begin
            tail_ent.refs = head_ent.refs - REFS_W'(1);
            if (head_ent.refs == REFS_W'(1)) begin
              move_next      = 1'b1;
              carry_ent_next = tail_ent;
              carry_id_next  = head_id;
            end
          end
        end else begin
          // Everything ahead of the target shifts back on a move
          tail_bmark = ~found;
        end
      end
      OP_MARK: begin
        if (slot_eq) begin
          tail_ent.valid = 1'b1;
        end
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // Next state and broadcast control
  always_comb begin
    state_next = state;
    s_tready   = (state == S_IDLE);
    accept     = s_tvalid && s_tready;
    fire       = (state == S_APPLY) && (!m_tvalid || m_tready);
    ctl.clr    = accept;
    ctl.step   = (state == S_SCAN);
    ctl.move   = fire && (op == OP_RELEASE) && move;
    ctl.retag  = fire && (op == OP_ACQUIRE) && !found && got;
    ctl.dev    = dev;
    ctl.blk    = blk;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_SCAN;
      S_SCAN:  if (cnt == ID_W'(SLOTS - 1)) state_next = S_APPLY;
      S_APPLY: if (fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the word, advance the pass, hold scan results
  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= op_t'(s_tuser);
      dev      <= s_tdata[7:0];
      blk      <= s_tdata[39:8];
      slot     <= s_tdata[43:40];
      cnt      <= '0;
      found    <= 1'b0;
      got      <= 1'b0;
      move     <= 1'b0;
      status   <= ST_OK;
      slot_out <= s_tdata[43:40];
      hit      <= 1'b0;
      fill     <= 1'b0;
    end else if (state == S_SCAN) begin
      cnt       <= cnt + ID_W'(1);
      found     <= found_next;
      got       <= got_next;
      move      <= move_next;
      status    <= status_next;
      slot_out  <= slot_out_next;
      hit       <= hit_next;
      fill      <= fill_next;
      victim    <= victim_next;
      carry_ent <= carry_ent_next;
      carry_id  <= carry_id_next;
    end
  end

  // Result register: load on apply, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (op == OP_ACQUIRE && !found) begin
        if (got) begin
          m_tdata <= {ST_OK, 1'b1, 1'b0, victim};
        end else begin
          m_tdata <= {ST_NOFREE, 1'b0, 1'b0, slot_out};
        end
      end else if (op == OP_RELEASE && !found) begin
        m_tdata <= {ST_UNREF, 1'b0, 1'b0, slot_out};
      end else begin
        m_tdata <= {status, fill, hit, slot_out};
      end
    end
  end

endmodule

`default_nettype wire
